// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-consequence and next-cycle implication checks on the rising clock
// edge, disabled while reset is asserted. Empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- design/ata_pio_pkg.sv -----
// ----------------------------------------------------------------------------
// ata_pio_pkg
// Field widths, codes, task-file offsets and command bytes of the ATA PIO
// transfer sequencer.
// ----------------------------------------------------------------------------
package ata_pio_pkg;

  localparam int unsigned LBA_W  = 48;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned SL_W   = 17;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CFG_DW = 64;
  localparam int unsigned CFG_AW = 5;

  // input item modes
  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_REG  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  // result operations
  localparam logic [2:0] OP_REG_WR  = 3'd0;
  localparam logic [2:0] OP_REG_RD  = 3'd1;
  localparam logic [2:0] OP_DATA_WR = 3'd2;
  localparam logic [2:0] OP_TO_HOST = 3'd3;
  localparam logic [2:0] OP_DONE    = 3'd4;

  // completion status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REJECT    = 2'd1;
  localparam logic [1:0] ST_DRIVE_ERR = 2'd2;
  localparam logic [1:0] ST_FAULT     = 2'd3;

  // task-file register offsets
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_ERROR   = 3'd1;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_LBA_LO  = 3'd3;
  localparam logic [2:0] REG_LBA_MID = 3'd4;
  localparam logic [2:0] REG_LBA_HI  = 3'd5;
  localparam logic [2:0] REG_DRIVE   = 3'd6;
  localparam logic [2:0] REG_CMD     = 3'd7;

  // drive register and command bytes
  localparam logic [7:0] DRV_LBA28 = 8'hE0;
  localparam logic [7:0] DRV_LBA48 = 8'h40;
  localparam logic [7:0] CMD_RD28  = 8'h20;
  localparam logic [7:0] CMD_WR28  = 8'h30;
  localparam logic [7:0] CMD_RD48  = 8'h24;
  localparam logic [7:0] CMD_WR48  = 8'h34;
  localparam logic [7:0] CMD_FLUSH = 8'hE7;

  // status register bits
  localparam logic [7:0] STS_ERR = 8'h01;
  localparam logic [7:0] STS_DRQ = 8'h08;
  localparam logic [7:0] STS_DF  = 8'h20;
  localparam logic [7:0] STS_RDY = 8'h40;
  localparam logic [7:0] STS_BSY = 8'h80;

  localparam logic [SL_W-1:0] LBA28_ZERO_COUNT = 17'd256;
  localparam logic [SL_W-1:0] LBA48_ZERO_COUNT = 17'd65536;

  // results per step kind
  localparam logic [IDX_W-1:0] LEN_ONE       = 4'd1;
  localparam logic [IDX_W-1:0] LEN_CMD28     = 4'd7;
  localparam logic [IDX_W-1:0] LEN_CMD48     = 4'd15;
  localparam logic [IDX_W-1:0] LEN_XFER_RD   = 4'd2;
  localparam logic [IDX_W-1:0] LEN_END       = 4'd6;
  localparam logic [IDX_W-1:0] LEN_END_FLUSH = 4'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_PORT_BASE = 2'd0;
  localparam logic [1:0] CFG_SLAVE     = 2'd1;
  localparam logic [1:0] CFG_LBA28     = 2'd2;
  localparam logic [1:0] CFG_CAPACITY  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RDY,
    PH_POLL,
    PH_ERRREG,
    PH_XFER,
    PH_FLUSH
  } phase_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_DONE,
    STEP_RD,
    STEP_CMD28,
    STEP_CMD48,
    STEP_XFER_MID,
    STEP_XFER_END
  } step_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [LBA_W-1:0] lba;
    logic [CNT_W-1:0] sector_total;
    logic             is_write;
    logic             use_lba48;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] address;
    logic [VAL_W-1:0]  data;
    logic [1:0]        status;
    logic [7:0]        error_value;
    logic              last;
  } result_t;

endpackage

// ----- design/ata_pio_ifs.sv -----
// ----------------------------------------------------------------------------
// ata_pio channel interfaces
// Valid/ready channels for command and read-back items and for bus results.
// ----------------------------------------------------------------------------
interface ata_pio_in_if import ata_pio_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [LBA_W-1:0] lba;
  logic [CNT_W-1:0] sector_total;
  logic             is_write;
  logic             use_lba48;
  logic [VAL_W-1:0] value;

  modport source (
    output valid, mode, lba, sector_total, is_write, use_lba48, value,
    input  ready
  );
  modport sink (
    input  valid, mode, lba, sector_total, is_write, use_lba48, value,
    output ready
  );
endinterface

interface ata_pio_out_if import ata_pio_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [ADDR_W-1:0] address;
  logic [VAL_W-1:0]  data;
  logic [1:0]        status;
  logic [7:0]        error_value;
  logic              last;

  modport source (
    output valid, op, address, data, status, error_value, last,
    input  ready
  );
  modport sink (
    input  valid, op, address, data, status, error_value, last,
    output ready
  );
endinterface

// ----- design/ata_pio_transfer_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// ata_pio_transfer_sequencer_top
// Host-side ATA PIO sequencer for one drive, 28-bit and 48-bit LBA. Command
// items turn into task-file writes and status reads; status bytes and data
// words fed back drive polling, sector transfer and the write cache flush.
// An accepted item sits in an input register while its bus operations leave
// one per cycle through the result register, while the output channel is
// ready. An item yields one result for a status poll or a written data word,
// two for a read data word, six or seven at a sector end and seven or fifteen
// for a 28-bit or 48-bit command; some items yield none. The next item is
// taken in the cycle its predecessor's last result is registered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ata_pio_transfer_sequencer_top import ata_pio_pkg::*; #(
  parameter int unsigned WORDS_PER_SECTOR = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  ata_pio_in_if.sink        in_chan,
  ata_pio_out_if.source     out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned WI_W = $clog2(WORDS_PER_SECTOR) + 1;

  logic [ADDR_W-1:0] base_r;
  logic              slave_r;
  logic              lba28_r;
  logic [LBA_W-1:0]  cap_r;

  item_t             in_r;
  logic              in_v_r;
  logic [IDX_W-1:0]  idx_r;
  result_t           out_r;
  logic              out_v_r;

  phase_t            phase_r, phase_nxt;
  logic [SL_W-1:0]   sl_r, sl_nxt;
  logic [WI_W-1:0]   wi_r, wi_nxt;
  logic              writing_r, writing_nxt;

  step_t             step;
  logic [IDX_W-1:0]  n;
  logic [2:0]        rd_off;
  logic [1:0]        done_st;
  logic [7:0]        done_ev;

  logic [7:0]        sts;
  logic [7:0]        c8;
  logic [SL_W-1:0]   eff28;
  logic [SL_W-1:0]   eff48;
  logic [LBA_W:0]    end48;
  logic              reject48;
  logic [WI_W-1:0]   wi_inc;
  logic              sec_end;
  logic [SL_W-1:0]   sl_dec;
  logic              last_sec;
  logic [7:0]        sl_bit;

  logic [2:0]        r_op;
  logic [2:0]        r_off;
  logic [VAL_W-1:0]  r_data;
  logic [1:0]        r_st;
  logic [7:0]        r_ev;
  result_t           res;

  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic              out_free;
  logic              emit;
  logic              step_done;
  logic              in_acc;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      CFG_PORT_BASE: cfg_prdata = {{(CFG_DW-ADDR_W){1'b0}}, base_r};
      CFG_SLAVE:     cfg_prdata = {{(CFG_DW-1){1'b0}}, slave_r};
      CFG_LBA28:     cfg_prdata = {{(CFG_DW-1){1'b0}}, lba28_r};
      CFG_CAPACITY:  cfg_prdata = {{(CFG_DW-LBA_W){1'b0}}, cap_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // step decode: result count and state after the step
  assign sts      = in_r.value[7:0];
  assign c8       = in_r.sector_total[7:0];
  assign eff28    = (c8 == 8'd0) ? LBA28_ZERO_COUNT : {{(SL_W-8){1'b0}}, c8};
  assign eff48    = (in_r.sector_total == '0) ? LBA48_ZERO_COUNT
                                              : {1'b0, in_r.sector_total};
  assign end48    = {1'b0, in_r.lba} + {{(LBA_W+1-SL_W){1'b0}}, eff48};
  assign reject48 = end48 > {1'b0, cap_r};
  assign wi_inc   = wi_r + WI_W'(1);
  assign sec_end  = wi_inc >= WI_W'(WORDS_PER_SECTOR);
  assign sl_dec   = (sl_r != '0) ? sl_r - SL_W'(1) : '0;
  assign last_sec = sl_dec == '0;
  assign sl_bit   = {3'b000, slave_r, 4'h0};

  always_comb begin
    step        = STEP_NONE;
    n           = '0;
    rd_off      = REG_CMD;
    done_st     = ST_OK;
    done_ev     = 8'h00;
    phase_nxt   = phase_r;
    sl_nxt      = sl_r;
    wi_nxt      = wi_r;
    writing_nxt = writing_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_r.mode == MODE_CMD) begin
          if ((!in_r.use_lba48 && !lba28_r) || (in_r.use_lba48 && reject48)) begin
            step        = STEP_DONE;
            n           = LEN_ONE;
            done_st     = ST_REJECT;
            sl_nxt      = '0;
            wi_nxt      = '0;
            writing_nxt = 1'b0;
          end else if (!in_r.use_lba48) begin
            step        = STEP_CMD28;
            n           = LEN_CMD28;
            sl_nxt      = eff28;
            wi_nxt      = '0;
            writing_nxt = in_r.is_write;
            phase_nxt   = PH_RDY;
          end else begin
            step        = STEP_CMD48;
            n           = LEN_CMD48;
            sl_nxt      = eff48;
            wi_nxt      = '0;
            writing_nxt = in_r.is_write;
            phase_nxt   = PH_POLL;
          end
        end
      end
      PH_RDY: begin
        if (in_r.mode == MODE_REG) begin
          step = STEP_RD;
          n    = LEN_ONE;
          if ((sts & STS_RDY) != 8'h00) begin
            phase_nxt = PH_POLL;
          end
        end
      end
      PH_POLL: begin
        if (in_r.mode == MODE_REG) begin
          if ((sts & STS_ERR) != 8'h00) begin
            step      = STEP_RD;
            n         = LEN_ONE;
            rd_off    = REG_ERROR;
            phase_nxt = PH_ERRREG;
          end else if ((sts & STS_DF) != 8'h00) begin
            step        = STEP_DONE;
            n           = LEN_ONE;
            done_st     = ST_FAULT;
            phase_nxt   = PH_IDLE;
            sl_nxt      = '0;
            wi_nxt      = '0;
            writing_nxt = 1'b0;
          end else if ((sts & STS_BSY) == 8'h00 && (sts & STS_DRQ) != 8'h00) begin
            wi_nxt    = '0;
            phase_nxt = PH_XFER;
            if (!writing_r) begin
              step   = STEP_RD;
              n      = LEN_ONE;
              rd_off = REG_DATA;
            end
          end else begin
            step = STEP_RD;
            n    = LEN_ONE;
          end
        end
      end
      PH_ERRREG: begin
        if (in_r.mode == MODE_REG) begin
          step        = STEP_DONE;
          n           = LEN_ONE;
          done_st     = ST_DRIVE_ERR;
          done_ev     = sts;
          phase_nxt   = PH_IDLE;
          sl_nxt      = '0;
          wi_nxt      = '0;
          writing_nxt = 1'b0;
        end
      end
      PH_XFER: begin
        if (in_r.mode == MODE_DATA) begin
          if (!sec_end) begin
            step   = STEP_XFER_MID;
            n      = writing_r ? LEN_ONE : LEN_XFER_RD;
            wi_nxt = wi_inc;
          end else begin
            step   = STEP_XFER_END;
            wi_nxt = '0;
            sl_nxt = sl_dec;
            if (!last_sec) begin
              n         = LEN_END;
              phase_nxt = PH_POLL;
            end else if (writing_r) begin
              n         = LEN_END_FLUSH;
              phase_nxt = PH_FLUSH;
            end else begin
              n           = LEN_END;
              phase_nxt   = PH_IDLE;
              sl_nxt      = '0;
              writing_nxt = 1'b0;
            end
          end
        end
      end
      PH_FLUSH: begin
        if (in_r.mode == MODE_REG) begin
          n = LEN_ONE;
          if ((sts & STS_BSY) != 8'h00) begin
            step = STEP_RD;
          end else begin
            step        = STEP_DONE;
            phase_nxt   = PH_IDLE;
            sl_nxt      = '0;
            wi_nxt      = '0;
            writing_nxt = 1'b0;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // result at the current position of the step
  always_comb begin
    r_op   = OP_REG_RD;
    r_off  = REG_CMD;
    r_data = '0;
    r_st   = ST_OK;
    r_ev   = 8'h00;
    case (step)
      STEP_DONE: begin
        r_op = OP_DONE;
        r_st = done_st;
        r_ev = done_ev;
      end
      STEP_RD: begin
        r_off = rd_off;
      end
      STEP_CMD28: begin
        r_op = OP_REG_WR;
        case (idx_r)
          4'd0: begin
            r_off  = REG_DRIVE;
            r_data = {8'h00, DRV_LBA28 | sl_bit | {4'h0, in_r.lba[27:24]}};
          end
          4'd1: begin
            r_off  = REG_COUNT;
            r_data = {8'h00, c8};
          end
          4'd2: begin
            r_off  = REG_LBA_LO;
            r_data = {8'h00, in_r.lba[7:0]};
          end
          4'd3: begin
            r_off  = REG_LBA_MID;
            r_data = {8'h00, in_r.lba[15:8]};
          end
          4'd4: begin
            r_off  = REG_LBA_HI;
            r_data = {8'h00, in_r.lba[23:16]};
          end
          4'd5: begin
            r_off  = REG_CMD;
            r_data = {8'h00, in_r.is_write ? CMD_WR28 : CMD_RD28};
          end
          default: begin
            r_op = OP_REG_RD;
          end
        endcase
      end
      STEP_CMD48: begin
        r_op = OP_REG_WR;
        case (idx_r)
          4'd0: begin
            r_off  = REG_DRIVE;
            r_data = {8'h00, DRV_LBA48 | sl_bit};
          end
          4'd1: begin
            r_off  = REG_COUNT;
            r_data = {8'h00, in_r.sector_total[15:8]};
          end
          4'd2: begin
            r_off  = REG_LBA_LO;
            r_data = {8'h00, in_r.lba[31:24]};
          end
          4'd3: begin
            r_off  = REG_LBA_MID;
            r_data = {8'h00, in_r.lba[39:32]};
          end
          4'd4: begin
            r_off  = REG_LBA_HI;
            r_data = {8'h00, in_r.lba[47:40]};
          end
          4'd5: begin
            r_off  = REG_COUNT;
            r_data = {8'h00, c8};
          end
          4'd6: begin
            r_off  = REG_LBA_LO;
            r_data = {8'h00, in_r.lba[7:0]};
          end
          4'd7: begin
            r_off  = REG_LBA_MID;
            r_data = {8'h00, in_r.lba[15:8]};
          end
          4'd8: begin
            r_off  = REG_LBA_HI;
            r_data = {8'h00, in_r.lba[23:16]};
          end
          4'd9: begin
            r_off  = REG_CMD;
            r_data = {8'h00, in_r.is_write ? CMD_WR48 : CMD_RD48};
          end
          default: begin
            r_op = OP_REG_RD;
          end
        endcase
      end
      STEP_XFER_MID, STEP_XFER_END: begin
        if (idx_r == '0) begin
          r_op   = writing_r ? OP_DATA_WR : OP_TO_HOST;
          r_off  = REG_DATA;
          r_data = in_r.value;
        end else if (step == STEP_XFER_MID) begin
          r_off = REG_DATA;
        end else if (idx_r == 4'd5 && last_sec) begin
          if (writing_r) begin
            r_op   = OP_REG_WR;
            r_data = {8'h00, CMD_FLUSH};
          end else begin
            r_op = OP_DONE;
          end
        end
      end
      default: begin
        r_op = OP_REG_RD;
      end
    endcase
  end

  always_comb begin
    res.op          = r_op;
    res.address     = (r_op == OP_TO_HOST || r_op == OP_DONE) ? '0
                                                             : base_r + {13'd0, r_off};
    res.data        = r_data;
    res.status      = r_st;
    res.error_value = r_ev;
    res.last        = idx_r == (n - IDX_W'(1));
  end

  assign out_free  = !out_v_r || out_chan.ready;
  assign emit      = in_v_r && (n != '0) && out_free;
  assign step_done = in_v_r && ((n == '0) || (emit && res.last));
  assign in_chan.ready = !in_v_r || step_done;
  assign in_acc    = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= 16'd496;
      slave_r   <= 1'b0;
      lba28_r   <= 1'b1;
      cap_r     <= '0;
      in_v_r    <= 1'b0;
      idx_r     <= '0;
      out_v_r   <= 1'b0;
      phase_r   <= PH_IDLE;
      sl_r      <= '0;
      wi_r      <= '0;
      writing_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          CFG_PORT_BASE: base_r  <= cfg_pwdata[ADDR_W-1:0];
          CFG_SLAVE:     slave_r <= cfg_pwdata[0];
          CFG_LBA28:     lba28_r <= cfg_pwdata[0];
          CFG_CAPACITY:  cap_r   <= cfg_pwdata[LBA_W-1:0];
          default:       base_r  <= base_r;
        endcase
      end
      if (in_acc) begin
        in_v_r <= 1'b1;
      end else if (step_done) begin
        in_v_r <= 1'b0;
      end
      if (step_done) begin
        idx_r     <= '0;
        phase_r   <= phase_nxt;
        sl_r      <= sl_nxt;
        wi_r      <= wi_nxt;
        writing_r <= writing_nxt;
      end else if (emit) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r.mode         <= in_chan.mode;
      in_r.lba          <= in_chan.lba;
      in_r.sector_total <= in_chan.sector_total;
      in_r.is_write     <= in_chan.is_write;
      in_r.use_lba48    <= in_chan.use_lba48;
      in_r.value        <= in_chan.value;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.op          = out_r.op;
  assign out_chan.address     = out_r.address;
  assign out_chan.data        = out_r.data;
  assign out_chan.status      = out_r.status;
  assign out_chan.error_value = out_r.error_value;
  assign out_chan.last        = out_r.last;

  `ASSERT_IMPLIES(a_idle_clear, clk, rst_n, phase_r == PH_IDLE, (sl_r == '0) && !writing_r && (wi_r == '0), "idle with leftover transfer state")
  `ASSERT_IMPLIES(a_xfer_sectors, clk, rst_n, phase_r == PH_XFER || phase_r == PH_POLL, sl_r != '0, "transfer phase with no sectors left")
  `ASSERT_IMPLIES(a_flush_write, clk, rst_n, phase_r == PH_FLUSH, writing_r, "flush wait on a read transfer")
  `ASSERT_IMPLIES(a_word_range, clk, rst_n, 1'b1, wi_r < WI_W'(WORDS_PER_SECTOR), "word index past sector end")
  `ASSERT_IMPLIES(a_idx_range, clk, rst_n, in_v_r && (n != '0), idx_r < n, "result position past step length")
  `ASSERT_NEXT(a_step_rewind, clk, rst_n, step_done, idx_r == '0, "result position not rewound after step")

endmodule
